@@ hw/rtl/iecsb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IEC serial bus device package
// Shared types, protocol states, event codes and timer commands.
// ----------------------------------------------------------------------------
package iecsb_pkg;

	typedef enum logic [3:0] {
		ST_RESET     = 4'd0,
		ST_IDLE      = 4'd1,
		ST_WAIT_TALK = 4'd2,
		ST_READY     = 4'd3,
		ST_RECEIVED  = 4'd4,
		ST_BECOMING  = 4'd5,
		ST_TALK_IDLE = 4'd6,
		ST_WAIT_ACC  = 4'd7,
		ST_WAIT_EOI  = 4'd8,
		ST_WRITING   = 4'd9,
		ST_WAIT_ACK  = 4'd10
	} proto_state_t;

	localparam logic [2:0] OP_ATN   = 3'd0;
	localparam logic [2:0] OP_CLOCK = 3'd1;
	localparam logic [2:0] OP_DATA  = 3'd2;
	localparam logic [2:0] OP_TIMER = 3'd3;
	localparam logic [2:0] OP_SEND  = 3'd4;
	localparam logic [2:0] OP_RESET = 3'd5;

	localparam logic [2:0] TMR_NONE     = 3'd0;
	localparam logic [2:0] TMR_STOP     = 3'd1;
	localparam logic [2:0] TMR_START_250 = 3'd2;
	localparam logic [2:0] TMR_START_40 = 3'd3;
	localparam logic [2:0] TMR_START_60 = 3'd4;

	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_LISTEN    = 4'd1;
	localparam logic [3:0] EV_TALK      = 4'd2;
	localparam logic [3:0] EV_UNLISTEN  = 4'd3;
	localparam logic [3:0] EV_UNTALK    = 4'd4;
	localparam logic [3:0] EV_OPEN      = 4'd5;
	localparam logic [3:0] EV_CLOSE     = 4'd6;
	localparam logic [3:0] EV_BECAME    = 4'd7;
	localparam logic [3:0] EV_DATA_BYTE = 4'd8;
	localparam logic [3:0] EV_SEND_OK   = 4'd9;
	localparam logic [3:0] EV_SEND_REJ  = 4'd10;
	localparam logic [3:0] EV_BUS_RESET = 4'd11;
	localparam logic [3:0] EV_BYTE_ACK  = 4'd12;

	localparam logic [4:0] DEV_RESET = 5'd8;
	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [2:0] operation;
		logic       atn_line;
		logic       clock_line;
		logic       data_line;
		logic       reset_line;
		logic [7:0] tx_byte;
		logic       tx_eoi;
	} item_t;

	typedef struct packed {
		logic       data_pull;
		logic       clock_pull;
		logic [6:0] hold_us;
		logic [2:0] timer_cmd;
		logic [3:0] event_res;
		logic [7:0] event_value;
		logic       drive_led;
		logic       last;
	} result_t;

	typedef struct packed {
		proto_state_t pstate;
		logic         attention;
		logic         listener;
		logic         talker;
		logic         eoi_seen;
		logic         send_with_eoi;
		logic [7:0]   shift_byte;
		logic [3:0]   bit_count;
		logic [1:0]   command_count;
		logic [7:0]   first_command;
		logic [7:0]   second_command;
		logic [7:0]   talk_channel;
		logic         data_drv;
		logic         clock_drv;
		logic         led_on;
	} core_state_t;

	localparam core_state_t CORE_RESET = '{
		pstate:         ST_RESET,
		attention:      1'b0,
		listener:       1'b0,
		talker:         1'b0,
		eoi_seen:       1'b0,
		send_with_eoi:  1'b0,
		shift_byte:     8'd0,
		bit_count:      4'd0,
		command_count:  2'd0,
		first_command:  8'd0,
		second_command: 8'd0,
		talk_channel:   8'd0,
		data_drv:       1'b0,
		clock_drv:      1'b0,
		led_on:         1'b0
	};

endpackage

@@ hw/rtl/iecsb_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IEC serial bus event channel
// Valid/ready channel that carries one bus event per transaction.
// ----------------------------------------------------------------------------
interface iecsb_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic       atn_line;
	logic       clock_line;
	logic       data_line;
	logic       reset_line;
	logic [7:0] tx_byte;
	logic       tx_eoi;

	modport source (
		output valid, operation, atn_line, clock_line, data_line, reset_line,
		       tx_byte, tx_eoi,
		input  ready
	);

	modport sink (
		input  valid, operation, atn_line, clock_line, data_line, reset_line,
		       tx_byte, tx_eoi,
		output ready
	);
endinterface

@@ hw/rtl/iecsb_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IEC serial bus result channel
// Valid/ready channel that carries one line drive and event result per
// transaction.
// ----------------------------------------------------------------------------
interface iecsb_result_if;
	logic       valid;
	logic       ready;
	logic       data_pull;
	logic       clock_pull;
	logic [6:0] hold_us;
	logic [2:0] timer_cmd;
	logic [3:0] event_res;
	logic [7:0] event_value;
	logic       drive_led;
	logic       last;

	modport source (
		output valid, data_pull, clock_pull, hold_us, timer_cmd, event_res,
		       event_value, drive_led, last,
		input  ready
	);

	modport sink (
		input  valid, data_pull, clock_pull, hold_us, timer_cmd, event_res,
		       event_value, drive_led, last,
		output ready
	);
endinterface

@@ hw/rtl/iec_serial_bus_device_interface.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IEC serial bus device interface
// Device side of the serial bus: command decode, byte reception and byte
// transmission driven by one bus event per transaction.
// ----------------------------------------------------------------------------
// An event transaction is held in an input register and handled by
// combinational logic, which yields one or two result transactions and the new
// protocol state. The results sit in a three-entry result buffer and leave on
// the result port at one per cycle while the port is ready. Most events give
// one result; two come from listen command decode with an open or close
// secondary, end of byte with EOI, EOI timeouts, bit transmission and the final
// acknowledge. The next event is taken in the cycle the last result of the
// previous one is accepted. The device number register may only be written
// while no event is outstanding.
module iec_serial_bus_device_interface
	import iecsb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	iecsb_item_if.sink      item,
	iecsb_result_if.source  result
);

	item_t         item_s1;
	logic          valid_s1;
	core_state_t   st_q;
	core_state_t   st_next;
	logic [4:0]    dev_q;
	result_t [2:0] res_q;
	result_t [2:0] step_res;
	logic [1:0]    step_count;
	logic [1:0]    res_left_q;
	logic [1:0]    res_rd_q;
	logic          pop;
	logic          buf_free;
	logic          consume;
	result_t       cur;

	iecsb_step u_step (
		.st        (st_q),
		.itm       (item_s1),
		.dev       (dev_q),
		.st_next   (st_next),
		.res       (step_res),
		.res_count (step_count)
	);

	assign pop      = (res_left_q != 2'd0) && result.ready;
	assign buf_free = (res_left_q == 2'd0) || ((res_left_q == 2'd1) && result.ready);
	assign consume  = valid_s1 && buf_free;
	assign item.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.operation  <= item.operation;
			item_s1.atn_line   <= item.atn_line;
			item_s1.clock_line <= item.clock_line;
			item_s1.data_line  <= item.data_line;
			item_s1.reset_line <= item.reset_line;
			item_s1.tx_byte    <= item.tx_byte;
			item_s1.tx_eoi     <= item.tx_eoi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= DEV_RESET;
		end else if (cfg_we) begin
			dev_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= CORE_RESET;
			res_left_q <= 2'd0;
			res_rd_q   <= 2'd0;
		end else if (consume) begin
			st_q       <= st_next;
			res_left_q <= step_count;
			res_rd_q   <= 2'd0;
		end else if (pop) begin
			res_left_q <= res_left_q - 2'd1;
			if (res_left_q > 2'd1) begin
				res_rd_q <= res_rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			res_q <= step_res;
		end
	end

	assign cur = res_q[res_rd_q];

	assign result.valid       = (res_left_q != 2'd0);
	assign result.data_pull   = cur.data_pull;
	assign result.clock_pull  = cur.clock_pull;
	assign result.hold_us     = cur.hold_us;
	assign result.timer_cmd   = cur.timer_cmd;
	assign result.event_res   = cur.event_res;
	assign result.event_value = cur.event_value;
	assign result.drive_led   = cur.drive_led;
	assign result.last        = cur.last;

	a_buf_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, res_rd_q} + {1'b0, res_left_q}) <= 3'd3)
		else $error("Result buffer read index runs past the stored results.");

	a_consume_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		consume |=> result.valid)
		else $error("An event was handled without a result transaction.");

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.last) |-> (res_left_q == 2'd1))
		else $error("The final result is not the last one in the buffer.");

	a_reset_released: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.pstate == ST_RESET) |-> (!st_q.data_drv && !st_q.clock_drv))
		else $error("Bus lines are driven in the bus reset state.");

endmodule

@@ hw/rtl/iecsb_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IEC serial bus protocol step
// Combinational next state and one or two results for one bus event.
// ----------------------------------------------------------------------------
module iecsb_step
	import iecsb_pkg::*;
(
	input  core_state_t     st,
	input  item_t           itm,
	input  logic [4:0]      dev,
	output core_state_t     st_next,
	output result_t [2:0]   res,
	output logic [1:0]      res_count
);

	localparam logic [6:0] HOLD_EOI_ACK = 7'd60;
	localparam logic [6:0] HOLD_BIT     = 7'd70;
	localparam logic [6:0] HOLD_TALK    = 7'd80;
	localparam logic [6:0] HOLD_ACK     = 7'd100;
	localparam logic [6:0] HOLD_EOI     = 7'd120;

	localparam logic [7:0] CMD_LISTEN   = 8'h20;
	localparam logic [7:0] CMD_UNLISTEN = 8'h3F;
	localparam logic [7:0] CMD_TALK     = 8'h40;
	localparam logic [7:0] CMD_UNTALK   = 8'h5F;
	localparam logic [7:0] CMD_SECOND   = 8'h60;
	localparam logic [7:0] CMD_OPEN     = 8'hE0;
	localparam logic [7:0] CMD_OPEN_TOP = 8'hEE;
	localparam logic [7:0] CMD_CLOSE    = 8'hF0;
	localparam logic [7:0] CMD_CLOSE_TOP = 8'hFE;

	function automatic result_t make_res(
		input core_state_t s,
		input logic [6:0]  hold,
		input logic [2:0]  tcmd,
		input logic [3:0]  ev,
		input logic [7:0]  val
	);
		result_t r;
		r.data_pull   = s.data_drv;
		r.clock_pull  = s.clock_drv;
		r.hold_us     = hold;
		r.timer_cmd   = tcmd;
		r.event_res   = ev;
		r.event_value = val;
		r.drive_led   = s.led_on;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic void push(
		inout result_t [2:0] r,
		inout logic [1:0]    n,
		input result_t       v
	);
		if (n != 2'd3) begin
			r[n] = v;
			n    = n + 2'd1;
		end
	endfunction

	core_state_t   s;
	result_t [2:0] r;
	logic [1:0]    n;
	logic          reset_st;
	logic          two;
	logic [7:0]    c;
	logic [7:0]    sc;
	logic [2:0]    tcmd;
	logic [3:0]    ev;
	logic [7:0]    val;

	always_comb begin
		s        = st;
		r        = '0;
		n        = 2'd0;
		reset_st = (st.pstate == ST_RESET);
		c        = st.first_command;
		sc       = st.second_command;
		two      = (st.command_count >= 2'd2);
		tcmd     = TMR_NONE;
		ev       = EV_NONE;
		val      = 8'd0;

		unique case (itm.operation)
			OP_ATN: begin
				if (!reset_st) begin
					if (!itm.atn_line) begin
						s.listener      = 1'b0;
						s.talker        = 1'b0;
						s.attention     = 1'b1;
						s.command_count = 2'd0;
						s.pstate        = ST_WAIT_TALK;
						s.clock_drv     = 1'b0;
						s.data_drv      = 1'b1;
						push(r, n, make_res(s, 7'd0, TMR_STOP, EV_NONE, 8'd0));
					end else begin
						s.attention = 1'b0;
						if (st.pstate != ST_RECEIVED || st.command_count == 2'd0) begin
							push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
						end else if (c == CMD_LISTEN + {3'd0, dev}) begin
							s.listener      = 1'b1;
							s.talker        = 1'b0;
							s.command_count = 2'd0;
							s.pstate        = ST_WAIT_TALK;
							push(r, n, make_res(s, 7'd0, TMR_NONE, EV_LISTEN, {3'd0, dev}));
							if (two && sc >= CMD_OPEN && sc <= CMD_OPEN_TOP) begin
								push(r, n, make_res(s, 7'd0, TMR_NONE, EV_OPEN, sc - CMD_OPEN));
							end else if (two && sc >= CMD_CLOSE && sc <= CMD_CLOSE_TOP) begin
								push(r, n, make_res(s, 7'd0, TMR_NONE, EV_CLOSE, sc - CMD_CLOSE));
							end
						end else if (c == CMD_TALK + {3'd0, dev}) begin
							s.talk_channel  = two ? sc - CMD_SECOND : 8'd0;
							s.command_count = 2'd0;
							s.pstate        = ST_BECOMING;
							push(r, n, make_res(s, 7'd0, TMR_NONE, EV_TALK, s.talk_channel));
						end else if (c == CMD_UNLISTEN) begin
							s.listener  = 1'b0;
							s.pstate    = ST_IDLE;
							s.data_drv  = 1'b0;
							s.clock_drv = 1'b0;
							push(r, n, make_res(s, 7'd0, TMR_NONE, EV_UNLISTEN, 8'd0));
						end else if (c == CMD_UNTALK) begin
							s.talker    = 1'b0;
							s.pstate    = ST_IDLE;
							s.data_drv  = 1'b0;
							s.clock_drv = 1'b0;
							push(r, n, make_res(s, 7'd0, TMR_NONE, EV_UNTALK, 8'd0));
						end else begin
							s.pstate    = ST_IDLE;
							s.data_drv  = 1'b0;
							s.clock_drv = 1'b0;
							push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
						end
					end
				end
			end
			OP_CLOCK: begin
				if (!reset_st && (st.listener || st.attention || st.pstate == ST_BECOMING)) begin
					if (itm.clock_line) begin
						if (st.pstate == ST_WAIT_TALK || st.pstate == ST_RECEIVED) begin
							s.shift_byte = 8'd0;
							s.bit_count  = 4'd0;
							s.pstate     = ST_READY;
							s.eoi_seen   = 1'b0;
							s.data_drv   = 1'b0;
							tcmd = st.attention ? TMR_NONE : TMR_START_250;
							push(r, n, make_res(s, 7'd0, tcmd, EV_NONE, 8'd0));
						end else if (st.pstate == ST_READY) begin
							if (itm.data_line && st.bit_count < 4'd8) begin
								s.shift_byte[st.bit_count[2:0]] = 1'b1;
							end
							s.bit_count = st.bit_count + 4'd1;
							if (s.bit_count < 4'd8) begin
								push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
							end else begin
								s.data_drv = 1'b1;
								if (st.attention) begin
									if (st.command_count == 2'd0) begin
										s.first_command = s.shift_byte;
									end else if (st.command_count == 2'd1) begin
										s.second_command = s.shift_byte;
									end
									if (st.command_count < 2'd2) begin
										s.command_count = st.command_count + 2'd1;
									end
								end
								ev  = st.attention ? EV_NONE : EV_DATA_BYTE;
								val = st.attention ? 8'd0 : s.shift_byte;
								if (st.eoi_seen) begin
									push(r, n, make_res(s, HOLD_EOI_ACK, TMR_NONE, ev, val));
									s.data_drv      = 1'b0;
									s.pstate        = ST_IDLE;
									s.command_count = 2'd0;
									push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
								end else begin
									s.pstate = ST_RECEIVED;
									push(r, n, make_res(s, 7'd0, TMR_NONE, ev, val));
								end
							end
						end else if (st.pstate == ST_BECOMING) begin
							s.data_drv  = 1'b0;
							s.clock_drv = 1'b1;
							s.talker    = 1'b1;
							s.listener  = 1'b0;
							s.pstate    = ST_TALK_IDLE;
							push(r, n, make_res(s, HOLD_TALK, TMR_NONE, EV_BECAME,
								st.talk_channel));
						end
					end else if (st.pstate == ST_READY) begin
						push(r, n, make_res(s, 7'd0, TMR_STOP, EV_NONE, 8'd0));
					end
				end
			end
			OP_DATA: begin
				if (!reset_st && st.talker) begin
					if (itm.data_line) begin
						if (st.pstate == ST_WAIT_ACC && st.send_with_eoi) begin
							s.pstate = ST_WAIT_EOI;
						end else if (st.pstate == ST_WAIT_ACC || st.pstate == ST_WAIT_EOI) begin
							s.led_on = 1'b1;
							s.pstate = ST_WRITING;
							push(r, n, make_res(s, 7'd0, TMR_START_40, EV_NONE, 8'd0));
						end
					end else if (st.pstate == ST_WAIT_ACK) begin
						push(r, n, make_res(s, st.send_with_eoi ? HOLD_EOI_ACK : HOLD_ACK,
							TMR_NONE, EV_NONE, 8'd0));
						s.led_on = 1'b0;
						s.pstate = ST_TALK_IDLE;
						push(r, n, make_res(s, 7'd0, TMR_NONE, EV_BYTE_ACK, st.shift_byte));
					end
				end
			end
			OP_TIMER: begin
				if (st.listener && st.pstate == ST_READY) begin
					s.eoi_seen = 1'b1;
					s.data_drv = 1'b1;
					push(r, n, make_res(s, HOLD_EOI, TMR_STOP, EV_NONE, 8'd0));
					s.data_drv = 1'b0;
					push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
				end else if (st.talker && st.pstate == ST_WRITING) begin
					if (st.bit_count >= 4'd8) begin
						s.data_drv  = 1'b0;
						s.clock_drv = 1'b1;
						s.pstate    = ST_WAIT_ACK;
						push(r, n, make_res(s, 7'd0, TMR_STOP, EV_NONE, 8'd0));
					end else begin
						s.clock_drv = 1'b1;
						s.data_drv  = !st.shift_byte[st.bit_count[2:0]];
						push(r, n, make_res(s, HOLD_BIT, TMR_STOP, EV_NONE, 8'd0));
						s.clock_drv = 1'b0;
						s.bit_count = st.bit_count + 4'd1;
						push(r, n, make_res(s, 7'd0, TMR_START_60, EV_NONE, 8'd0));
					end
				end
			end
			OP_SEND: begin
				if (!st.talker || reset_st || st.pstate >= ST_WAIT_ACC) begin
					push(r, n, make_res(s, 7'd0, TMR_NONE, EV_SEND_REJ, 8'd0));
				end else begin
					s.shift_byte    = itm.tx_byte;
					s.bit_count     = 4'd0;
					s.send_with_eoi = itm.tx_eoi;
					s.pstate        = ST_WAIT_ACC;
					s.clock_drv     = 1'b0;
					push(r, n, make_res(s, 7'd0, TMR_NONE, EV_SEND_OK, 8'd0));
				end
			end
			OP_RESET: begin
				if (!itm.reset_line) begin
					s.led_on = 1'b1;
					if (!reset_st) begin
						s.pstate    = ST_RESET;
						s.attention = 1'b0;
						s.listener  = 1'b0;
						s.talker    = 1'b0;
						s.eoi_seen  = 1'b0;
						s.data_drv  = 1'b0;
						s.clock_drv = 1'b0;
						tcmd = TMR_STOP;
					end
					push(r, n, make_res(s, 7'd0, tcmd, EV_BUS_RESET, 8'd0));
				end else begin
					s.led_on = 1'b0;
					if (reset_st) begin
						s.pstate    = ST_IDLE;
						s.data_drv  = 1'b0;
						s.clock_drv = 1'b0;
					end
					push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
				end
			end
			default: begin
			end
		endcase

		if (n == 2'd0) begin
			push(r, n, make_res(s, 7'd0, TMR_NONE, EV_NONE, 8'd0));
		end
		r[n - 2'd1].last = 1'b1;
	end

	assign st_next   = s;
	assign res       = r;
	assign res_count = n;

endmodule

@@ bench/iec_serial_bus_device_interface_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IEC serial bus device interface testbench
// Drives bus event transactions through a queue-fed driver and checks every
// result transaction against an in-bench model of the device protocol, over
// several device numbers, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module iec_serial_bus_device_interface_tb;
	import iecsb_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam logic [7:0] CMD_LISTEN    = 8'h20;
	localparam logic [7:0] CMD_UNLISTEN  = 8'h3F;
	localparam logic [7:0] CMD_TALK      = 8'h40;
	localparam logic [7:0] CMD_UNTALK    = 8'h5F;
	localparam logic [7:0] CMD_SECONDARY = 8'h60;
	localparam logic [7:0] CMD_OPEN      = 8'hE0;
	localparam logic [7:0] CMD_OPEN_END  = 8'hEE;
	localparam logic [7:0] CMD_CLOSE     = 8'hF0;
	localparam logic [7:0] CMD_CLOSE_END = 8'hFE;

	localparam int HOLD_FRAME_END = 60;
	localparam int HOLD_BIT       = 70;
	localparam int HOLD_TURNROUND = 80;
	localparam int HOLD_ACK       = 100;
	localparam int HOLD_EOI       = 120;

	localparam int SC_LISTEN       = 0;
	localparam int SC_TALK         = 1;
	localparam int SC_RELEASE      = 2;
	localparam int SC_THREE_CMDS   = 3;
	localparam int SC_NO_SECONDARY = 4;
	localparam int SC_BUS_RESET    = 5;
	localparam int SC_NOISE        = 6;
	localparam int SC_FOREIGN      = 7;
	localparam int SC_BROKEN       = 8;
	localparam int SC_COUNT        = 9;

	localparam int PHASES      = 4;
	localparam int PHASE_ITEMS = 55;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;

	iecsb_item_if   bus_event ();
	iecsb_result_if bus_result ();

	iec_serial_bus_device_interface i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (bus_event),
		.result   (bus_result)
	);

	always #5 clk = ~clk;

	// Device model state
	logic [4:0]   dev_num;
	proto_state_t st;
	logic         attn, lsn, tlk, eoi_seen, send_eoi;
	logic [7:0]   shifter;
	logic [3:0]   nbits;
	logic [1:0]   ncmd;
	logic [7:0]   cmd0, cmd1, talk_ch;
	logic         drv_data, drv_clock, led;

	result_t step_results[$];
	result_t expected_results[$];
	item_t   bus_events[$];

	int events_posted   = 0;
	int events_accepted = 0;
	int results_seen    = 0;
	int errors          = 0;
	int long_hold_at    = -1;
	bit long_hold_done  = 1'b0;
	bit idling_on       = 1'b1;

	function automatic void bus_device_reset();
		dev_num   = DEV_RESET;
		st        = ST_RESET;
		attn      = 1'b0;
		lsn       = 1'b0;
		tlk       = 1'b0;
		eoi_seen  = 1'b0;
		send_eoi  = 1'b0;
		shifter   = 8'd0;
		nbits     = 4'd0;
		ncmd      = 2'd0;
		cmd0      = 8'd0;
		cmd1      = 8'd0;
		talk_ch   = 8'd0;
		drv_data  = 1'b0;
		drv_clock = 1'b0;
		led       = 1'b0;
		expected_results.delete();
	endfunction

	function automatic void add_result(int hold, logic [2:0] tcmd, logic [3:0] ev, int val);
		result_t r;
		if (step_results.size() >= MAX_RESULTS)
			return;
		r.data_pull   = drv_data;
		r.clock_pull  = drv_clock;
		r.hold_us     = 7'(hold);
		r.timer_cmd   = tcmd;
		r.event_res   = ev;
		r.event_value = 8'(val);
		r.drive_led   = led;
		r.last        = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void go_idle();
		st        = ST_IDLE;
		drv_data  = 1'b0;
		drv_clock = 1'b0;
	endfunction

	function automatic void start_byte();
		shifter  = 8'd0;
		nbits    = 4'd0;
		st       = ST_READY;
		eoi_seen = 1'b0;
		drv_data = 1'b0;
		add_result(0, attn ? TMR_NONE : TMR_START_250, EV_NONE, 0);
	endfunction

	function automatic void shift_in_bit(logic b);
		if (b && nbits < 4'd8)
			shifter[nbits[2:0]] = 1'b1;
		nbits = nbits + 4'd1;
		if (nbits < 4'd8) begin
			add_result(0, TMR_NONE, EV_NONE, 0);
			return;
		end
		drv_data = 1'b1;
		if (attn) begin
			if (ncmd == 2'd0)
				cmd0 = shifter;
			else if (ncmd == 2'd1)
				cmd1 = shifter;
			if (ncmd < 2'd2)
				ncmd = ncmd + 2'd1;
		end
		if (eoi_seen) begin
			add_result(HOLD_FRAME_END, TMR_NONE, attn ? EV_NONE : EV_DATA_BYTE,
				attn ? 0 : shifter);
			drv_data = 1'b0;
			st       = ST_IDLE;
			ncmd     = 2'd0;
			add_result(0, TMR_NONE, EV_NONE, 0);
		end else begin
			st = ST_RECEIVED;
			add_result(0, TMR_NONE, attn ? EV_NONE : EV_DATA_BYTE, attn ? 0 : shifter);
		end
	endfunction

	function automatic void decode_command();
		logic two;
		two  = (ncmd >= 2'd2);
		attn = 1'b0;
		if (st != ST_RECEIVED || ncmd == 2'd0) begin
			add_result(0, TMR_NONE, EV_NONE, 0);
			return;
		end
		if (int'(cmd0) == int'(CMD_LISTEN) + int'(dev_num) && cmd0 <= CMD_UNLISTEN) begin
			lsn  = 1'b1;
			tlk  = 1'b0;
			ncmd = 2'd0;
			st   = ST_WAIT_TALK;
			add_result(0, TMR_NONE, EV_LISTEN, dev_num);
			if (two && cmd1 >= CMD_OPEN && cmd1 <= CMD_OPEN_END)
				add_result(0, TMR_NONE, EV_OPEN, cmd1 - CMD_OPEN);
			else if (two && cmd1 >= CMD_CLOSE && cmd1 <= CMD_CLOSE_END)
				add_result(0, TMR_NONE, EV_CLOSE, cmd1 - CMD_CLOSE);
		end else if (int'(cmd0) == int'(CMD_TALK) + int'(dev_num) && cmd0 <= CMD_UNTALK) begin
			talk_ch = two ? 8'(cmd1 - CMD_SECONDARY) : 8'd0;
			ncmd    = 2'd0;
			st      = ST_BECOMING;
			add_result(0, TMR_NONE, EV_TALK, talk_ch);
		end else if (cmd0 == CMD_UNLISTEN) begin
			lsn = 1'b0;
			go_idle();
			add_result(0, TMR_NONE, EV_UNLISTEN, 0);
		end else if (cmd0 == CMD_UNTALK) begin
			tlk = 1'b0;
			go_idle();
			add_result(0, TMR_NONE, EV_UNTALK, 0);
		end else begin
			go_idle();
			add_result(0, TMR_NONE, EV_NONE, 0);
		end
	endfunction

	function automatic void bus_device_step(item_t ev);
		logic in_reset;
		in_reset = (st == ST_RESET);
		step_results.delete();
		case (ev.operation)
			OP_ATN: begin
				if (!in_reset) begin
					if (!ev.atn_line) begin
						lsn       = 1'b0;
						tlk       = 1'b0;
						attn      = 1'b1;
						ncmd      = 2'd0;
						st        = ST_WAIT_TALK;
						drv_clock = 1'b0;
						drv_data  = 1'b1;
						add_result(0, TMR_STOP, EV_NONE, 0);
					end else begin
						decode_command();
					end
				end
			end
			OP_CLOCK: begin
				if (!in_reset && (lsn || attn || st == ST_BECOMING)) begin
					if (ev.clock_line) begin
						if (st == ST_WAIT_TALK || st == ST_RECEIVED) begin
							start_byte();
						end else if (st == ST_READY) begin
							shift_in_bit(ev.data_line);
						end else if (st == ST_BECOMING) begin
							drv_data  = 1'b0;
							drv_clock = 1'b1;
							tlk       = 1'b1;
							lsn       = 1'b0;
							st        = ST_TALK_IDLE;
							add_result(HOLD_TURNROUND, TMR_NONE, EV_BECAME, talk_ch);
						end
					end else if (st == ST_READY) begin
						add_result(0, TMR_STOP, EV_NONE, 0);
					end
				end
			end
			OP_DATA: begin
				if (!in_reset && tlk) begin
					if (ev.data_line) begin
						if (st == ST_WAIT_ACC && send_eoi) begin
							st = ST_WAIT_EOI;
						end else if (st == ST_WAIT_ACC || st == ST_WAIT_EOI) begin
							led = 1'b1;
							st  = ST_WRITING;
							add_result(0, TMR_START_40, EV_NONE, 0);
						end
					end else if (st == ST_WAIT_ACK) begin
						add_result(send_eoi ? HOLD_FRAME_END : HOLD_ACK, TMR_NONE, EV_NONE, 0);
						led = 1'b0;
						st  = ST_TALK_IDLE;
						add_result(0, TMR_NONE, EV_BYTE_ACK, shifter);
					end
				end
			end
			OP_TIMER: begin
				if (lsn && st == ST_READY) begin
					eoi_seen = 1'b1;
					drv_data = 1'b1;
					add_result(HOLD_EOI, TMR_STOP, EV_NONE, 0);
					drv_data = 1'b0;
					add_result(0, TMR_NONE, EV_NONE, 0);
				end else if (tlk && st == ST_WRITING) begin
					if (nbits >= 4'd8) begin
						drv_data  = 1'b0;
						drv_clock = 1'b1;
						st        = ST_WAIT_ACK;
						add_result(0, TMR_STOP, EV_NONE, 0);
					end else begin
						drv_clock = 1'b1;
						drv_data  = ~shifter[nbits[2:0]];
						add_result(HOLD_BIT, TMR_STOP, EV_NONE, 0);
						drv_clock = 1'b0;
						nbits     = nbits + 4'd1;
						add_result(0, TMR_START_60, EV_NONE, 0);
					end
				end
			end
			OP_SEND: begin
				if (!tlk || in_reset || st >= ST_WAIT_ACC) begin
					add_result(0, TMR_NONE, EV_SEND_REJ, 0);
				end else begin
					shifter   = ev.tx_byte;
					nbits     = 4'd0;
					send_eoi  = ev.tx_eoi;
					st        = ST_WAIT_ACC;
					drv_clock = 1'b0;
					add_result(0, TMR_NONE, EV_SEND_OK, 0);
				end
			end
			OP_RESET: begin
				if (!ev.reset_line) begin
					led = 1'b1;
					if (!in_reset) begin
						st        = ST_RESET;
						attn      = 1'b0;
						lsn       = 1'b0;
						tlk       = 1'b0;
						eoi_seen  = 1'b0;
						drv_data  = 1'b0;
						drv_clock = 1'b0;
					end
					add_result(0, in_reset ? TMR_NONE : TMR_STOP, EV_BUS_RESET, 0);
				end else begin
					led = 1'b0;
					if (in_reset)
						go_idle();
					add_result(0, TMR_NONE, EV_NONE, 0);
				end
			end
			default: ;
		endcase
		if (step_results.size() == 0)
			add_result(0, TMR_NONE, EV_NONE, 0);
		step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endfunction

	function automatic int pick_idle();
		int r;
		if (!idling_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic rbit();
		return 1'($urandom);
	endfunction

	function automatic void post_item(item_t ev);
		bus_events.push_back(ev);
		events_posted++;
	endfunction

	function automatic void post_event(logic [2:0] op, logic lvl, logic dat);
		item_t ev;
		ev = 16'($urandom);
		ev.operation = op;
		case (op)
			OP_ATN:   ev.atn_line = lvl;
			OP_CLOCK: begin
				ev.clock_line = lvl;
				ev.data_line  = dat;
			end
			OP_DATA:  ev.data_line = lvl;
			OP_RESET: ev.reset_line = lvl;
			default: ;
		endcase
		post_item(ev);
	endfunction

	function automatic void post_fixed(logic [2:0] op, logic fill);
		item_t ev;
		ev = fill ? '1 : '0;
		ev.operation = op;
		post_item(ev);
	endfunction

	function automatic void post_send(logic [7:0] b, logic eoi);
		item_t ev;
		ev = 16'($urandom);
		ev.operation = OP_SEND;
		ev.tx_byte   = b;
		ev.tx_eoi    = eoi;
		post_item(ev);
	endfunction

	function automatic void post_byte(logic [7:0] b, logic eoi);
		post_event(OP_CLOCK, 1'b1, rbit());
		if (eoi) begin
			post_event(OP_TIMER, rbit(), rbit());
			if ($urandom_range(0, 2) == 0)
				post_event(OP_TIMER, rbit(), rbit());
		end
		for (int i = 0; i < 8; i++) begin
			post_event(OP_CLOCK, 1'b0, rbit());
			post_event(OP_CLOCK, 1'b1, b[i]);
		end
	endfunction

	function automatic void post_command(int n, logic [7:0] c0, logic [7:0] c1,
		logic [7:0] c2);
		post_event(OP_ATN, 1'b0, rbit());
		post_byte(c0, 1'b0);
		if (n > 1)
			post_byte(c1, 1'b0);
		if (n > 2)
			post_byte(c2, 1'b0);
		post_event(OP_ATN, 1'b1, rbit());
	endfunction

	function automatic void post_talk_byte();
		logic [7:0] b;
		logic       eoi;
		b   = 8'($urandom);
		eoi = rbit();
		post_send(b, eoi);
		post_event(OP_DATA, 1'b1, 1'b0);
		if (eoi)
			post_event(OP_DATA, 1'b1, 1'b0);
		if ($urandom_range(0, 3) == 0)
			post_send(8'($urandom), rbit());
		repeat (9)
			post_event(OP_TIMER, rbit(), rbit());
		if ($urandom_range(0, 3) == 0)
			post_event(OP_TIMER, rbit(), rbit());
		post_event(OP_DATA, 1'b0, 1'b0);
	endfunction

	function automatic void post_scenario(int sc, logic [4:0] dev);
		int         n;
		logic [7:0] sec;
		case (sc)
			SC_LISTEN: begin
				case ($urandom_range(0, 3))
					0: sec = 8'(CMD_OPEN + $urandom_range(0, 15));
					1: sec = 8'(CMD_CLOSE + $urandom_range(0, 15));
					2: sec = 8'(CMD_SECONDARY + $urandom_range(0, 15));
					default: sec = 8'($urandom);
				endcase
				post_command(2, 8'(CMD_LISTEN + dev), sec, 8'd0);
				n = $urandom_range(1, 2);
				for (int i = 0; i < n; i++)
					post_byte(8'($urandom), (i == n - 1) ? rbit() : 1'b0);
			end
			SC_TALK: begin
				if ($urandom_range(0, 3) == 0)
					sec = 8'($urandom);
				else
					sec = 8'(CMD_SECONDARY + $urandom_range(0, 15));
				post_command(2, 8'(CMD_TALK + dev), sec, 8'd0);
				post_event(OP_CLOCK, 1'b1, rbit());
				repeat ($urandom_range(1, 2))
					post_talk_byte();
			end
			SC_RELEASE: begin
				post_command(1, rbit() ? CMD_UNLISTEN : CMD_UNTALK, 8'd0, 8'd0);
			end
			SC_THREE_CMDS: begin
				post_command(3, 8'(CMD_LISTEN + dev), 8'(CMD_CLOSE + $urandom_range(0, 15)),
					8'($urandom));
			end
			SC_NO_SECONDARY: begin
				if (rbit()) begin
					post_command(1, 8'(CMD_LISTEN + dev), 8'd0, 8'd0);
					post_byte(8'($urandom), 1'b1);
				end else begin
					post_command(1, 8'(CMD_TALK + dev), 8'd0, 8'd0);
					post_event(OP_CLOCK, 1'b1, rbit());
					post_send(8'($urandom), 1'b0);
					post_event(OP_DATA, 1'b1, 1'b0);
					post_event(OP_TIMER, rbit(), rbit());
				end
			end
			SC_BUS_RESET: begin
				post_event(OP_RESET, 1'b0, rbit());
				repeat ($urandom_range(1, 3))
					post_item(16'($urandom));
				post_event(OP_RESET, 1'b1, rbit());
			end
			SC_NOISE: begin
				repeat ($urandom_range(4, 8))
					post_item(16'($urandom));
				post_event(OP_RESET, 1'b1, rbit());
			end
			SC_FOREIGN: begin
				post_command(1, 8'($urandom), 8'd0, 8'd0);
			end
			default: begin
				post_event(OP_ATN, 1'b0, rbit());
				post_event(OP_CLOCK, 1'b1, rbit());
				repeat ($urandom_range(1, 4)) begin
					post_event(OP_CLOCK, 1'b0, rbit());
					post_event(OP_CLOCK, 1'b1, rbit());
				end
				post_event(OP_ATN, 1'b1, rbit());
			end
		endcase
	endfunction

	function automatic int pick_scenario();
		int r;
		r = $urandom_range(0, 11);
		if (r < 3)
			return SC_LISTEN;
		if (r < 6)
			return SC_TALK;
		if (r < 7)
			return SC_RELEASE;
		if (r < 8)
			return SC_THREE_CMDS;
		if (r < 9)
			return SC_NO_SECONDARY;
		if (r < 10)
			return SC_FOREIGN;
		if (r < 11)
			return SC_BROKEN;
		return rbit() ? SC_BUS_RESET : SC_NOISE;
	endfunction

	function automatic void compare_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function automatic void check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			$error("result transaction with nothing expected: event %0d value %0d",
				bus_result.event_res, bus_result.event_value);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("data_pull", want.data_pull, bus_result.data_pull);
		compare_field("clock_pull", want.clock_pull, bus_result.clock_pull);
		compare_field("hold_us", want.hold_us, bus_result.hold_us);
		compare_field("timer_cmd", want.timer_cmd, bus_result.timer_cmd);
		compare_field("event_res", want.event_res, bus_result.event_res);
		compare_field("event_value", want.event_value, bus_result.event_value);
		compare_field("drive_led", want.drive_led, bus_result.drive_led);
		compare_field("last", want.last, bus_result.last);
	endfunction

	item_t offered;
	int    send_wait;
	int    stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_event.valid      <= 1'b0;
			bus_event.operation  <= OP_ATN;
			bus_event.atn_line   <= 1'b1;
			bus_event.clock_line <= 1'b1;
			bus_event.data_line  <= 1'b1;
			bus_event.reset_line <= 1'b1;
			bus_event.tx_byte    <= 8'd0;
			bus_event.tx_eoi     <= 1'b0;
			send_wait = 0;
			bus_device_reset();
		end else begin
			if (bus_event.valid && bus_event.ready) begin
				bus_device_step(offered);
				events_accepted++;
			end
			if (!bus_event.valid || bus_event.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					bus_event.valid <= 1'b0;
				end else if (bus_events.size() != 0) begin
					offered = bus_events.pop_front();
					bus_event.operation  <= offered.operation;
					bus_event.atn_line   <= offered.atn_line;
					bus_event.clock_line <= offered.clock_line;
					bus_event.data_line  <= offered.data_line;
					bus_event.reset_line <= offered.reset_line;
					bus_event.tx_byte    <= offered.tx_byte;
					bus_event.tx_eoi     <= offered.tx_eoi;
					bus_event.valid      <= 1'b1;
					send_wait = pick_idle();
				end else begin
					bus_event.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_result.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (bus_result.valid && bus_result.ready) begin
				check_result();
				results_seen++;
			end
			if (results_seen == long_hold_at && !long_hold_done) begin
				// A long hold-off lets the result buffer fill and stalls event input.
				stall_left     = 200;
				long_hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				bus_result.ready <= 1'b0;
			end else begin
				bus_result.ready <= 1'b1;
				stall_left = pick_idle();
			end
		end
	end

	task automatic wait_until_idle();
		while (events_accepted != events_posted || expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_device_number(logic [4:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		dev_num = d;
	endtask

	initial begin : stimulus
		logic [4:0] phase_dev [PHASES];
		int         next_forced;
		int         phase_start;
		phase_dev[0] = DEV_RESET;
		phase_dev[1] = 5'd0;
		phase_dev[2] = 5'd30;
		phase_dev[3] = 5'($urandom_range(1, 29));
		next_forced  = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 5'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			wait_until_idle();
			write_device_number(phase_dev[p]);
			idling_on = (p != 2);
			if (p == 0) begin
				// Starts in bus reset: sends are rejected, all but RESET is ignored.
				post_event(OP_ATN, 1'b0, 1'b0);
				post_event(OP_CLOCK, 1'b1, 1'b1);
				post_event(OP_TIMER, 1'b0, 1'b0);
				post_send(8'hFF, 1'b1);
				post_event(OP_RESET, 1'b0, 1'b0);
				post_event(OP_RESET, 1'b1, 1'b0);
				post_fixed(OP_SPARE_LO, 1'b1);
				post_fixed(OP_SPARE_HI, 1'b0);
				post_fixed(OP_SPARE_HI, 1'b1);
				post_send(8'h00, 1'b0);
				post_event(OP_DATA, 1'b1, 1'b0);
				post_event(OP_DATA, 1'b0, 1'b0);
				post_fixed(OP_TIMER, 1'b1);
				post_event(OP_ATN, 1'b1, 1'b0);
				post_event(OP_ATN, 1'b0, 1'b0);
				post_event(OP_CLOCK, 1'b0, 1'b0);
				post_event(OP_ATN, 1'b1, 1'b0);
				post_event(OP_RESET, 1'b0, 1'b0);
				post_fixed(OP_RESET, 1'b1);
			end
			phase_start = events_posted;
			while (events_posted - phase_start < PHASE_ITEMS) begin
				if (next_forced < SC_COUNT) begin
					post_scenario(next_forced, phase_dev[p]);
					next_forced++;
				end else begin
					post_scenario(pick_scenario(), phase_dev[p]);
				end
			end
			if (p == 1)
				long_hold_at = results_seen + 30;
		end
		wait_until_idle();
		repeat (10) @(posedge clk);
		$display("Run covered %0d bus event transactions and %0d result transactions.",
			events_accepted, results_seen);
		$display("Device numbers %0d, %0d, %0d and %0d; listen, talk, bus reset and noise.",
			phase_dev[0], phase_dev[1], phase_dev[2], phase_dev[3]);
		if (errors == 0)
			$display("iec_serial_bus_device_interface_tb: clean");
		else
			$display("iec_serial_bus_device_interface_tb: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out waiting for the device to finish.");
		$display("iec_serial_bus_device_interface_tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/iecsb_pkg.sv
hw/rtl/iecsb_item_if.sv
hw/rtl/iecsb_result_if.sv
hw/rtl/iecsb_step.sv
hw/rtl/iec_serial_bus_device_interface.sv
bench/iec_serial_bus_device_interface_tb.sv
